// ----- rtl/csp_forward_check_engine_assert.svh -----
// assertion macros shared by the forward-check engine
`ifndef CSP_FORWARD_CHECK_ENGINE_ASSERT_SVH
`define CSP_FORWARD_CHECK_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CFCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CFCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cfce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfce_pkg
// Field widths, request and register codes and the shared-unit types of the
// forward-check engine.
// ----------------------------------------------------------------------------
package cfce_pkg;

    // field widths fixed by the interface
    localparam int REQ_W      = 3;
    localparam int VAR_W      = 4;
    localparam int VAL_W      = 4;
    localparam int ROW_W      = 16;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 1;

    // largest variable and value counts the fields can address
    localparam int FIELD_VARS = 16;
    localparam int FIELD_VALS = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_ROW = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_DOM = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ASSIGN   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_DOM = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    // operands of the shared mask unit
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] dom;
        logic [ROW_W-1:0] vmask;
        logic [VAL_W-1:0] bit_sel;
    } t_unit_in;

    // results of the shared mask unit
    typedef struct packed {
        logic             bit_clear;
        logic [ROW_W-1:0] dom_new;
        logic             dom_empty;
    } t_unit_out;

endpackage

// ----- rtl/cfce_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfce_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module cfce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cfce_mask_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfce_mask_unit
// Shared bit test and domain prune unit, used once per visited variable.
// ----------------------------------------------------------------------------
module cfce_mask_unit (
    input  cfce_pkg::t_unit_in  i_op,
    output cfce_pkg::t_unit_out o_res
);

    logic [cfce_pkg::ROW_W-1:0] dom_new;

    // prune only the in-use values, keep the rest of the domain
    assign dom_new         = i_op.dom & (i_op.row | ~i_op.vmask);
    assign o_res.dom_new   = dom_new;
    assign o_res.dom_empty = ((dom_new & i_op.vmask) == '0);
    // forbidden tuple when the selected row bit is clear
    assign o_res.bit_clear = ~i_op.row[i_op.bit_sel];

endmodule

// ----- rtl/csp_forward_check_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_forward_check_engine
// Forward-checking helper for binary constraint search: relation rows, pair
// flags, domains and assignments, with check and assign-and-prune walks.
// ----------------------------------------------------------------------------
// One request is worked at a time. Loads, domain reads and unknown requests
// pass from acceptance through the finish state into the output register. A
// check walks the variables below var_a and stops early when a conflict is
// found; an assign walks var_a + 1 up to the variable count. The walk is
// paced by the single read port of the relation-row memory, one row per
// variable per cycle, with the shared mask unit one stage behind it. A
// finished word waits in the output register while the next request is
// accepted. Relation rows that were never written read as anything; there is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "csp_forward_check_engine_assert.svh"

module csp_forward_check_engine #(
    parameter int NUM_VARS = 16,
    parameter int NUM_VALS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [cfce_pkg::REQ_W-1:0]      i_req_type,
    input  logic [cfce_pkg::VAR_W-1:0]      i_var_a,
    input  logic [cfce_pkg::VAR_W-1:0]      i_var_b,
    input  logic [cfce_pkg::VAL_W-1:0]      i_value,
    input  logic [cfce_pkg::ROW_W-1:0]      i_row_bits,
    input  logic                            i_pair_present,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_violates,
    output logic                            o_wipeout,
    output logic [cfce_pkg::ROW_W-1:0]      o_domain_bits,
    output logic                            o_domain_empty,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [cfce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfce_pkg::CNT_W-1:0]      i_cfg_data
);

    localparam int VARS_USED = (NUM_VARS < cfce_pkg::FIELD_VARS) ? NUM_VARS
                                                                 : cfce_pkg::FIELD_VARS;
    localparam int VALS_USED = (NUM_VALS < cfce_pkg::FIELD_VALS) ? NUM_VALS
                                                                 : cfce_pkg::FIELD_VALS;
    localparam int VW         = $clog2(VARS_USED);
    localparam int LW         = $clog2(VALS_USED);
    localparam int PW         = 2 * VW;
    localparam int RW         = PW + LW;
    localparam int PAIR_DEPTH = 1 << PW;
    localparam int ROW_DEPTH  = 1 << RW;
    localparam int KW         = cfce_pkg::CNT_W;
    localparam logic [cfce_pkg::ROW_W-1:0] ROW_MASK =
        (VALS_USED >= cfce_pkg::ROW_W) ? '1 : cfce_pkg::ROW_W'((1 << VALS_USED) - 1);
    localparam logic [KW-1:0] VARS_LIM = KW'(VARS_USED);
    localparam logic [KW-1:0] VALS_LIM = KW'(VALS_USED);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // sequencer and result registers
    logic [1:0]                    r_state, n_state;
    logic [cfce_pkg::REQ_W-1:0]    r_req, n_req;
    logic [cfce_pkg::VAR_W-1:0]    r_va, n_va;
    logic [cfce_pkg::VAL_W-1:0]    r_v, n_v;
    logic [KW-1:0]                 r_k, n_k;
    logic [KW-1:0]                 r_end, n_end;
    logic                          r_ev_vld, n_ev_vld;
    logic [KW-1:0]                 r_ev_k;
    logic                          r_ev_rowok;
    logic                          r_ev_pv;
    logic                          r_viol, n_viol;
    logic                          r_wipe, n_wipe;
    logic [cfce_pkg::ROW_W-1:0]    r_dbits, n_dbits;
    logic                          r_dempty, n_dempty;
    logic                          r_out_vld;
    logic                          r_out_viol;
    logic                          r_out_wipe;
    logic [cfce_pkg::ROW_W-1:0]    r_out_dbits;
    logic                          r_out_dempty;
    logic [KW-1:0]                 r_var_count;
    logic [KW-1:0]                 r_val_count;

    // per-variable state
    logic [cfce_pkg::ROW_W-1:0]    r_dom [VARS_USED];
    logic [cfce_pkg::VAL_W-1:0]    r_asg [VARS_USED];
    logic [PAIR_DEPTH-1:0]         r_pair_vld;

    logic                          in_acc;
    logic                          va_ok, vb_ok, v_ok;
    logic [VW-1:0]                 ia_idx, ib_idx;
    logic                          ld_row;
    logic [RW-1:0]                 wr_addr;
    logic                          issue_act;
    logic [VW-1:0]                 iss_idx, ev_idx;
    logic [cfce_pkg::VAL_W-1:0]    asg_k;
    logic [RW-1:0]                 rd_addr;
    logic                          rowok_iss;
    logic [cfce_pkg::ROW_W-1:0]    row_rdata;
    logic [0:0]                    pair_rdata;
    logic                          ev_present;
    logic                          hit;
    logic [KW-1:0]                 nv, nvl;
    logic [cfce_pkg::ROW_W-1:0]    vmask;
    logic [cfce_pkg::ROW_W-1:0]    rd_dom;
    cfce_pkg::t_unit_in            unit_in;
    cfce_pkg::t_unit_out           unit_out;

    // request handshake and range checks
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign va_ok      = ({1'b0, i_var_a} < VARS_LIM);
    assign vb_ok      = ({1'b0, i_var_b} < VARS_LIM);
    assign v_ok       = ({1'b0, i_value} < VALS_LIM);
    assign ia_idx     = i_var_a[VW-1:0];
    assign ib_idx     = i_var_b[VW-1:0];
    assign ld_row     = in_acc && (i_req_type == cfce_pkg::REQ_LOAD_ROW) && va_ok && vb_ok;
    assign wr_addr    = {ia_idx, ib_idx, i_value[LW-1:0]};
    assign rd_dom     = va_ok ? r_dom[ia_idx] : '0;

    // effective counts and in-use value mask
    assign nv  = (r_var_count < VARS_LIM) ? r_var_count : VARS_LIM;
    assign nvl = (r_val_count < VALS_LIM) ? r_val_count : VALS_LIM;
    always_comb begin
        for (int i = 0; i < cfce_pkg::ROW_W; i++) begin
            vmask[i] = (KW'(i) < nvl);
        end
    end

    // issue side of the walk: one row address per cycle
    assign issue_act = (r_state == ST_WALK) && (r_k < r_end);
    assign iss_idx   = r_k[VW-1:0];
    assign asg_k     = issue_act ? r_asg[iss_idx] : '0;
    always_comb begin
        if (r_req == cfce_pkg::REQ_CHECK) begin
            rd_addr   = {iss_idx, r_va[VW-1:0], asg_k[LW-1:0]};
            rowok_iss = ({1'b0, asg_k} < VALS_LIM);
        end else begin
            rd_addr   = {r_va[VW-1:0], iss_idx, r_v[LW-1:0]};
            rowok_iss = ({1'b0, r_v} < VALS_LIM);
        end
    end

    cfce_ram #(
        .WIDTH (cfce_pkg::ROW_W),
        .DEPTH (ROW_DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ld_row && v_ok),
        .i_waddr (wr_addr),
        .i_wdata (i_row_bits & ROW_MASK),
        .i_raddr (rd_addr),
        .o_rdata (row_rdata)
    );

    cfce_ram #(
        .WIDTH (1),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (ld_row),
        .i_waddr (wr_addr[RW-1:LW]),
        .i_wdata (i_pair_present),
        .i_raddr (rd_addr[RW-1:LW]),
        .o_rdata (pair_rdata)
    );

    // evaluate side: an absent pair passes an all-ones row
    assign ev_idx     = r_ev_k[VW-1:0];
    assign ev_present = r_ev_vld && r_ev_pv && pair_rdata[0];
    always_comb begin
        unit_in.row     = ev_present ? (r_ev_rowok ? row_rdata : '0) : '1;
        unit_in.dom     = r_ev_vld ? r_dom[ev_idx] : '0;
        unit_in.vmask   = vmask;
        unit_in.bit_sel = r_v;
    end

    cfce_mask_unit u_mask_unit (
        .i_op  (unit_in),
        .o_res (unit_out)
    );

    assign hit = r_ev_vld && (r_req == cfce_pkg::REQ_CHECK) && unit_out.bit_clear;

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_va     = r_va;
        n_v      = r_v;
        n_k      = r_k;
        n_end    = r_end;
        n_ev_vld = 1'b0;
        n_viol   = r_viol;
        n_wipe   = r_wipe;
        n_dbits  = r_dbits;
        n_dempty = r_dempty;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_req    = i_req_type;
                    n_va     = i_var_a;
                    n_v      = i_value;
                    n_viol   = 1'b0;
                    n_wipe   = 1'b0;
                    n_dbits  = '0;
                    n_dempty = 1'b0;
                    n_state  = ST_FIN;
                    unique case (i_req_type)
                        cfce_pkg::REQ_CHECK: begin
                            n_k     = '0;
                            n_end   = va_ok ? {1'b0, i_var_a} : '0;
                            n_state = ST_WALK;
                        end
                        cfce_pkg::REQ_ASSIGN: begin
                            n_k     = {1'b0, i_var_a} + KW'(1);
                            n_end   = nv;
                            n_state = ST_WALK;
                        end
                        cfce_pkg::REQ_READ_DOM: begin
                            n_dbits  = rd_dom;
                            n_dempty = (rd_dom == '0);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (issue_act && !hit) begin
                    n_ev_vld = 1'b1;
                    n_k      = r_k + KW'(1);
                end
                if (r_ev_vld && (r_req == cfce_pkg::REQ_ASSIGN) && unit_out.dom_empty) begin
                    n_wipe = 1'b1;
                end
                if (hit) begin
                    n_viol  = 1'b1;
                    n_state = ST_FIN;
                end else if (!issue_act && !r_ev_vld) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer, configuration and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ev_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_var_count <= cfce_pkg::CNT_RESET;
            r_val_count <= cfce_pkg::CNT_RESET;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= n_ev_vld;
            if (i_cfg_we) begin
                if (i_cfg_index == cfce_pkg::CFG_VAR_COUNT) begin
                    r_var_count <= i_cfg_data;
                end else begin
                    r_val_count <= i_cfg_data;
                end
            end
            if ((r_state == ST_FIN) && (!r_out_vld || !i_out_stall)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request, walk and result payload
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_va       <= n_va;
        r_v        <= n_v;
        r_k        <= n_k;
        r_end      <= n_end;
        r_viol     <= n_viol;
        r_wipe     <= n_wipe;
        r_dbits    <= n_dbits;
        r_dempty   <= n_dempty;
        r_ev_k     <= r_k;
        r_ev_rowok <= rowok_iss;
        r_ev_pv    <= r_pair_vld[rd_addr[RW-1:LW]];
        if ((r_state == ST_FIN) && (!r_out_vld || !i_out_stall)) begin
            r_out_viol   <= r_viol;
            r_out_wipe   <= r_wipe;
            r_out_dbits  <= r_dbits;
            r_out_dempty <= r_dempty;
        end
    end

    // domains, assignments and pair flag valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VARS_USED; i++) begin
                r_dom[i] <= '0;
                r_asg[i] <= '0;
            end
            r_pair_vld <= '0;
        end else begin
            if (in_acc && (i_req_type == cfce_pkg::REQ_LOAD_DOM) && va_ok) begin
                r_dom[ia_idx] <= i_row_bits & ROW_MASK;
            end
            if (in_acc && (i_req_type == cfce_pkg::REQ_ASSIGN) && va_ok) begin
                r_asg[ia_idx] <= i_value;
            end
            if (ld_row) begin
                r_pair_vld[wr_addr[RW-1:LW]] <= 1'b1;
            end
            if (r_ev_vld && (r_req == cfce_pkg::REQ_ASSIGN)) begin
                r_dom[ev_idx] <= unit_out.dom_new;
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_violates     = r_out_viol;
    assign o_wipeout      = r_out_wipe;
    assign o_domain_bits  = r_out_dbits;
    assign o_domain_empty = r_out_dempty;

    // checks on the sequencer
    `CFCE_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall, "not busy after accept")
    `CFCE_ASSERT_IMP(a_eval_in_walk, i_clk, i_rst_n, r_ev_vld, r_state == ST_WALK, "eval outside walk")
    `CFCE_ASSERT_IMP(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_vld), $past(r_state) == ST_FIN, "word not from finish")
    `CFCE_ASSERT_IMP(a_viol_alone, i_clk, i_rst_n, o_out_valid && o_violates, !o_wipeout && (o_domain_bits == '0) && !o_domain_empty, "conflict word mixed")

endmodule

// ----- verif/tb_csp_forward_check_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csp_forward_check_engine
// Self-checking bench for the forward-check engine. A queue of requests feeds
// a driver on the falling edge. A monitor on the rising edge keeps a
// bit-accurate copy of the relation rows, pair flags, domains and assignments.
// It works out the result word of every accepted request and checks the words
// that come out, in order. After a short directed run, search-like sequences,
// pair loads and random noise run through several count settings and idling
// mixes.
// ----------------------------------------------------------------------------
module tb_csp_forward_check_engine;

    // widths and codes of the engine
    localparam int REQ_W     = cfce_pkg::REQ_W;
    localparam int VAR_W     = cfce_pkg::VAR_W;
    localparam int VAL_W     = cfce_pkg::VAL_W;
    localparam int ROW_W     = cfce_pkg::ROW_W;
    localparam int CNT_W     = cfce_pkg::CNT_W;
    localparam int CFG_IDX_W = cfce_pkg::CFG_IDX_W;
    localparam logic [REQ_W-1:0]     REQ_LOAD_ROW  = cfce_pkg::REQ_LOAD_ROW;
    localparam logic [REQ_W-1:0]     REQ_LOAD_DOM  = cfce_pkg::REQ_LOAD_DOM;
    localparam logic [REQ_W-1:0]     REQ_CHECK     = cfce_pkg::REQ_CHECK;
    localparam logic [REQ_W-1:0]     REQ_ASSIGN    = cfce_pkg::REQ_ASSIGN;
    localparam logic [REQ_W-1:0]     REQ_READ_DOM  = cfce_pkg::REQ_READ_DOM;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT = cfce_pkg::CFG_VAR_COUNT;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL_COUNT = cfce_pkg::CFG_VAL_COUNT;

    localparam int NV            = cfce_pkg::FIELD_VARS;
    localparam int NVAL          = cfce_pkg::FIELD_VALS;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [VAR_W-1:0] va;
        logic [VAR_W-1:0] vb;
        logic [VAL_W-1:0] val;
        logic [ROW_W-1:0] bits;
        logic             pres;
    } t_request;

    typedef struct packed {
        logic             violates;
        logic             wipeout;
        logic [ROW_W-1:0] dom_bits;
        logic             dom_empty;
    } t_outcome;

    // block ports, all inputs known from time zero
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic [REQ_W-1:0]   i_req_type     = '0;
    logic [VAR_W-1:0]   i_var_a        = '0;
    logic [VAR_W-1:0]   i_var_b        = '0;
    logic [VAL_W-1:0]   i_value        = '0;
    logic [ROW_W-1:0]   i_row_bits     = '0;
    logic               i_pair_present = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic               o_violates;
    logic               o_wipeout;
    logic [ROW_W-1:0]   o_domain_bits;
    logic               o_domain_empty;
    logic               i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CNT_W-1:0]   i_cfg_data     = '0;

    // stimulus and checking state
    t_request request_q[$];
    t_outcome outcome_q[$];
    logic     req_fire      = 1'b0;
    int       in_idle_pct   = 0;
    int       out_stall_pct = 0;
    int       queued_count  = 0;
    int       bad_words     = 0;

    // rows written so far per pair, one bit per row index
    logic [NVAL-1:0] row_seen [NV][NV] = '{default: '0};

    // mirror of the engine state
    logic [ROW_W-1:0] rel_mem [NV][NV][NVAL] = '{default: '0};
    logic             pair_on [NV][NV]       = '{default: 1'b0};
    logic [ROW_W-1:0] dom_mem [NV]           = '{default: '0};
    logic [VAL_W-1:0] asg_val [NV]           = '{default: '0};
    int               var_cnt                = int'(cfce_pkg::CNT_RESET);
    int               val_cnt                = int'(cfce_pkg::CNT_RESET);

    csp_forward_check_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_var_a        (i_var_a),
        .i_var_b        (i_var_b),
        .i_value        (i_value),
        .i_row_bits     (i_row_bits),
        .i_pair_present (i_pair_present),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_violates     (o_violates),
        .o_wipeout      (o_wipeout),
        .o_domain_bits  (o_domain_bits),
        .o_domain_empty (o_domain_empty),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // one request applied to the mirrored state, giving its result word
    function automatic t_outcome search_step(t_request w);
        t_outcome         o;
        int               k;
        int               nv;
        int               nval;
        logic [ROW_W-1:0] vm;
        o    = '0;
        nv   = (var_cnt < NV) ? var_cnt : NV;
        nval = (val_cnt < NVAL) ? val_cnt : NVAL;
        vm   = (nval >= ROW_W) ? '1 : ROW_W'((1 << nval) - 1);
        case (w.req)
            REQ_LOAD_ROW: begin
                pair_on[w.va][w.vb]        = w.pres;
                rel_mem[w.va][w.vb][w.val] = w.bits;
            end
            REQ_LOAD_DOM: begin
                dom_mem[w.va] = w.bits;
            end
            REQ_CHECK: begin
                // any earlier constrained variable whose row forbids this value
                for (k = 0; k < int'(w.va); k++) begin
                    if (pair_on[k][w.va] && !rel_mem[k][w.va][asg_val[k]][w.val])
                        o.violates = 1'b1;
                end
            end
            REQ_ASSIGN: begin
                asg_val[w.va] = w.val;
                // prune later domains, values above the in-use count untouched
                for (k = int'(w.va) + 1; k < nv; k++) begin
                    if (pair_on[w.va][k])
                        dom_mem[k] = dom_mem[k] & (rel_mem[w.va][k][w.val] | ~vm);
                end
                for (k = int'(w.va) + 1; k < nv; k++) begin
                    if ((dom_mem[k] & vm) == '0)
                        o.wipeout = 1'b1;
                end
            end
            REQ_READ_DOM: begin
                o.dom_bits  = dom_mem[w.va];
                o.dom_empty = (dom_mem[w.va] == '0);
            end
            default: ;
        endcase
        return o;
    endfunction

    // driver: next word on the falling edge once the last one was taken
    always @(negedge i_clk) begin : driver
        t_request nxt;
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
        if (i_rst_n && (!i_in_valid || req_fire)) begin
            if (request_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                nxt = request_q.pop_front();
                i_req_type     <= nxt.req;
                i_var_a        <= nxt.va;
                i_var_b        <= nxt.vb;
                i_value        <= nxt.val;
                i_row_bits     <= nxt.bits;
                i_pair_present <= nxt.pres;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor: register writes, accepted requests and result words
    always @(posedge i_clk) begin : monitor
        t_outcome seen;
        t_outcome want;
        t_request taken;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
        end else begin
            req_fire <= i_in_valid && !o_in_stall;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_VAR_COUNT)
                    var_cnt = int'(i_cfg_data);
                else
                    val_cnt = int'(i_cfg_data);
            end
            if (o_out_valid && !i_out_stall) begin
                seen = '{o_violates, o_wipeout, o_domain_bits, o_domain_empty};
                if (outcome_q.size() == 0) begin
                    bad_words++;
                    if (bad_words <= MAX_SHOWN)
                        $display("unrequested result word: viol=%0b wipe=%0b dom=%h empty=%0b",
                                 seen.violates, seen.wipeout, seen.dom_bits, seen.dom_empty);
                end else begin
                    want = outcome_q.pop_front();
                    if (seen !== want) begin
                        bad_words++;
                        if (bad_words <= MAX_SHOWN)
                            $display(
                                "mismatch: expected %0b %0b %h %0b, got %0b %0b %h %0b",
                                want.violates, want.wipeout, want.dom_bits, want.dom_empty,
                                seen.violates, seen.wipeout, seen.dom_bits, seen.dom_empty);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                taken = '{i_req_type, i_var_a, i_var_b, i_value, i_row_bits, i_pair_present};
                outcome_q.push_back(search_step(taken));
            end
        end
    end

    // queue one request
    task automatic push_req(input logic [REQ_W-1:0] req, input logic [VAR_W-1:0] va,
                            input logic [VAR_W-1:0] vb, input logic [VAL_W-1:0] val,
                            input logic [ROW_W-1:0] bits, input logic pres);
        t_request w;
        w = '{req, va, vb, val, bits, pres};
        if (req == REQ_LOAD_ROW) begin
            row_seen[va][vb][val] = 1'b1;
            // the flag only goes up on a pair with every row written, so no
            // walk ever reads a row that holds nothing
            if (row_seen[va][vb] != '1)
                w.pres = 1'b0;
        end
        request_q.push_back(w);
        queued_count++;
    endtask

    function automatic logic [ROW_W-1:0] dense_bits();
        return ROW_W'($urandom | $urandom);
    endfunction

    function automatic logic [ROW_W-1:0] domain_pick();
        int r;
        r = $urandom_range(7);
        if (r < 2)
            return '1;
        else if (r == 7)
            return ROW_W'($urandom);
        return dense_bits();
    endfunction

    // all rows of one variable pair, flag raised, if at all, with the last one
    task automatic gen_pair();
        int a;
        int b;
        int v;
        logic down;
        if ($urandom_range(9) == 0) begin
            a = $urandom_range(NV - 1);
            b = $urandom_range(NV - 1);
        end else begin
            a = $urandom_range(NV - 2);
            b = $urandom_range(NV - 1, a + 1);
        end
        down = 1'($urandom_range(1));
        for (v = 0; v < NVAL; v++)
            push_req(REQ_LOAD_ROW, VAR_W'(a), VAR_W'(b), VAL_W'(down ? NVAL - 1 - v : v),
                     dense_bits(), (v == NVAL - 1) && ($urandom_range(9) != 0));
    endtask

    // load domains, then check and assign variable by variable
    task automatic gen_search();
        int n;
        int i;
        n = ($urandom_range(3) == 0) ? NV : $urandom_range(6, 2);
        for (i = 0; i < n; i++)
            push_req(REQ_LOAD_DOM, VAR_W'(i), VAR_W'($urandom), VAL_W'($urandom),
                     domain_pick(), 1'($urandom));
        for (i = 0; i < n; i++) begin
            repeat ($urandom_range(3, 1))
                push_req(REQ_CHECK, VAR_W'(i), VAR_W'($urandom), VAL_W'($urandom),
                         ROW_W'($urandom), 1'($urandom));
            push_req(REQ_ASSIGN, VAR_W'(i), VAR_W'($urandom), VAL_W'($urandom),
                     ROW_W'($urandom), 1'($urandom));
            if ($urandom_range(2) == 0)
                push_req(REQ_READ_DOM, VAR_W'($urandom), VAR_W'($urandom),
                         VAL_W'($urandom), ROW_W'($urandom), 1'($urandom));
        end
    endtask

    // single check, assign, read or domain load on a random variable
    task automatic gen_probe();
        logic [REQ_W-1:0] req;
        case ($urandom_range(3))
            0: req = REQ_CHECK;
            1: req = REQ_ASSIGN;
            2: req = REQ_READ_DOM;
            default: req = REQ_LOAD_DOM;
        endcase
        push_req(req, VAR_W'($urandom), VAR_W'($urandom), VAL_W'($urandom),
                 domain_pick(), 1'($urandom));
    endtask

    // wait for the engine to go quiet
    task automatic drain();
        while (request_q.size() != 0 || i_in_valid || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_counts(input logic [CNT_W-1:0] vars, input logic [CNT_W-1:0] vals);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_VAR_COUNT;
        i_cfg_data  <= vars;
        @(negedge i_clk);
        i_cfg_index <= CFG_VAL_COUNT;
        i_cfg_data  <= vals;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // one setting of the counts and the idling mix
    task automatic run_phase(input int vars, input int vals, input int in_pct,
                             input int out_pct, input int n_items);
        int r;
        drain();
        write_counts(CNT_W'(vars), CNT_W'(vals));
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        queued_count  = 0;
        while (queued_count < n_items) begin
            r = $urandom_range(99);
            if (r < 18)
                gen_pair();
            else if (r < 45)
                gen_search();
            else if (r < 85)
                gen_probe();
            else
                push_req(REQ_W'($urandom), VAR_W'($urandom), VAR_W'($urandom),
                         VAL_W'($urandom), ROW_W'($urandom), 1'($urandom));
        end
    endtask

    // run limit
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty state reads, unknown codes, field extremes
        push_req(REQ_READ_DOM, 4'd0, 4'd0, 4'd0, 16'h0000, 1'b0);
        push_req(REQ_READ_DOM, 4'd15, 4'd15, 4'd15, 16'hFFFF, 1'b1);
        push_req(3'd5, 4'd15, 4'd15, 4'd15, 16'hFFFF, 1'b1);
        push_req(3'd6, 4'd0, 4'd0, 4'd0, 16'h0000, 1'b0);
        push_req(3'd7, 4'd15, 4'd0, 4'd15, 16'h5A5A, 1'b1);
        push_req(REQ_LOAD_DOM, 4'd15, 4'd0, 4'd0, 16'hFFFF, 1'b0);
        push_req(REQ_LOAD_DOM, 4'd0, 4'd0, 4'd0, 16'h0000, 1'b0);
        push_req(REQ_LOAD_DOM, 4'd1, 4'd0, 4'd0, 16'hA5A5, 1'b0);
        push_req(REQ_READ_DOM, 4'd15, 4'd0, 4'd0, 16'h0000, 1'b0);
        push_req(REQ_READ_DOM, 4'd1, 4'd0, 4'd0, 16'h0000, 1'b0);
        push_req(REQ_READ_DOM, 4'd0, 4'd0, 4'd0, 16'h0000, 1'b0);
        push_req(REQ_CHECK, 4'd0, 4'd0, 4'd15, 16'h0000, 1'b0);
        push_req(REQ_CHECK, 4'd15, 4'd0, 4'd0, 16'h0000, 1'b0);
        // last variable has nothing later, first variable sees empty domains
        push_req(REQ_ASSIGN, 4'd15, 4'd15, 4'd15, 16'hFFFF, 1'b1);
        push_req(REQ_ASSIGN, 4'd0, 4'd0, 4'd0, 16'h0000, 1'b0);
        // partial row load leaves the pair unconstrained
        push_req(REQ_LOAD_ROW, 4'd14, 4'd15, 4'd15, 16'hFFFF, 1'b1);
        push_req(REQ_CHECK, 4'd15, 4'd0, 4'd3, 16'h0000, 1'b0);
        push_req(REQ_READ_DOM, 4'd14, 4'd0, 4'd0, 16'h0000, 1'b0);

        run_phase(16, 16, 0, 0, 160);
        run_phase(31, 31, 46, 0, 140);
        run_phase(0, 0, 0, 46, 60);
        run_phase(1, 1, 6, 6, 100);
        run_phase($urandom_range(15, 2), $urandom_range(15, 2), 46, 0, 140);
        run_phase(16, 8, 0, 46, 150);
        drain();

        if (bad_words == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cfce_pkg.sv
rtl/cfce_ram.sv
rtl/cfce_mask_unit.sv
rtl/csp_forward_check_engine.sv
verif/tb_csp_forward_check_engine.sv
